// ===== design/bale_pkg.sv =====
// Package for the bounded array list engine.
// Holds sizes, command and status codes, FSM state and the controller/datapath structs.
// No dependencies.
package bale_pkg;

  localparam int unsigned CAP   = 64;
  localparam int unsigned IDX_W = $clog2(CAP);
  localparam int unsigned LEN_W = $clog2(CAP + 1);
  localparam int unsigned EW    = 32;
  localparam int unsigned CMD_W = 4;
  localparam int unsigned POS_W = 7;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 4'd0,
    CMD_INSERT   = 4'd1,
    CMD_DELETE   = 4'd2,
    CMD_READ     = 4'd3,
    CMD_WRITE    = 4'd4,
    CMD_FIND     = 4'd5,
    CMD_SORT_INS = 4'd6,
    CMD_REMOVE   = 4'd7,
    CMD_DEL_RUN  = 4'd8,
    CMD_REVERSE  = 4'd9
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // index register update
  typedef enum logic [2:0] {
    IX_KEEP, IX_ZERO, IX_LEN, IX_LEN_M1, IX_POS, IX_POS_RUN, IX_INC, IX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    LN_KEEP, LN_INC, LN_SUB_RUN, LN_FROM_K
  } len_op_e;

  typedef enum logic [1:0] {
    WA_I, WA_J, WA_K, WA_POS
  } wa_sel_e;

  typedef enum logic [1:0] {
    WD_VAL, WD_RDA, WD_RDB
  } wd_sel_e;

  typedef enum logic [1:0] {
    PS_KEEP, PS_LEN, PS_I
  } pos_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_INS_RD, S_INS_WR,
    S_DEL_SET, S_DEL_RD, S_DEL_WR,
    S_RD_ISSUE, S_RD_WAIT,
    S_FIND_RD, S_FIND_CHK,
    S_SORT_RD, S_SORT_CHK,
    S_REM_RD, S_REM_CHK,
    S_REV_RD, S_REV_WA, S_REV_WB,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    load_in;
    logic    run_one;
    idx_op_e i_op;
    idx_op_e j_op;
    idx_op_e k_op;
    pos_op_e pos_op;
    len_op_e len_op;
    logic    rd_en;
    logic    wr_en;
    wa_sel_e wa_sel;
    wd_sel_e wd_sel;
    logic    set_status;
    status_e status;
    logic    cap_rd;
    logic    cap_fidx;
    logic    out_load;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic pos_gt_len;
    logic pos_ge_len;
    logic full;
    logic run_bad;
    logic i_lt_len;
    logic k_gt_pos;
    logic i_lt_j;
    logic hit;
    logic less;
  } dp_stat_t;

endpackage

// ===== design/bounded_array_list_engine.sv =====
// Bounded array list engine: one command word in, one result word out.
// Throughput: one command at a time; the next is taken the cycle after the result is
// loaded, even while that result waits on a stall.
// Reset (async, active low) empties the list; memory contents are not cleared.
module bounded_array_list_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bale_pkg::CMD_W-1:0]        command_i,
  input  logic [bale_pkg::POS_W-1:0]        position_i,
  input  logic [bale_pkg::POS_W-1:0]        run_count_i,
  input  logic signed [bale_pkg::EW-1:0]    value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bale_pkg::ST_W-1:0]         status_o,
  output logic signed [bale_pkg::EW-1:0]    read_value_o,
  output logic [bale_pkg::IDX_W-1:0]        found_index_o,
  output logic [bale_pkg::LEN_W-1:0]        list_length_o
);
  import bale_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  bale_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  bale_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .command_i     (command_i),
    .position_i    (position_i),
    .run_count_i   (run_count_i),
    .value_i       (value_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .found_index_o (found_index_o),
    .list_length_o (list_length_o)
  );

endmodule

// ===== design/bale_dpath.sv =====
// Datapath of the list engine: element memory, length, index registers, result registers.
// Depends on bale_pkg; driven by bale_ctrl.
module bale_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bale_pkg::dp_ctrl_t                ctrl_i,
  output bale_pkg::dp_stat_t                stat_o,
  input  logic [bale_pkg::CMD_W-1:0]        command_i,
  input  logic [bale_pkg::POS_W-1:0]        position_i,
  input  logic [bale_pkg::POS_W-1:0]        run_count_i,
  input  logic signed [bale_pkg::EW-1:0]    value_i,
  output logic [bale_pkg::ST_W-1:0]         status_o,
  output logic signed [bale_pkg::EW-1:0]    read_value_o,
  output logic [bale_pkg::IDX_W-1:0]        found_index_o,
  output logic [bale_pkg::LEN_W-1:0]        list_length_o
);
  import bale_pkg::*;

  logic signed [EW-1:0] mem [CAP];

  cmd_e                 cmd_q;
  logic [LEN_W-1:0]     pos_q, run_q;
  logic signed [EW-1:0] val_q;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [LEN_W-1:0]     i_q, j_q, k_q;
  logic signed [EW-1:0] rda_q, rdb_q;
  status_e              res_st_q;
  logic signed [EW-1:0] res_rd_q;
  logic [IDX_W-1:0]     res_fidx_q;
  logic [IDX_W-1:0]     wa;
  logic signed [EW-1:0] wd;
  logic [LEN_W:0]       pos_run;

  function automatic logic [LEN_W-1:0] idx_next(idx_op_e op, logic [LEN_W-1:0] cur,
                                                logic [LEN_W-1:0] len,
                                                logic [LEN_W-1:0] pos,
                                                logic [LEN_W-1:0] run);
    logic [LEN_W-1:0] r;
    unique case (op)
      IX_KEEP:    r = cur;
      IX_ZERO:    r = '0;
      IX_LEN:     r = len;
      IX_LEN_M1:  r = (len == '0) ? '0 : len - LEN_W'(1);
      IX_POS:     r = pos;
      IX_POS_RUN: r = pos + run;
      IX_INC:     r = cur + LEN_W'(1);
      IX_DEC:     r = cur - LEN_W'(1);
      default:    r = cur;
    endcase
    return r;
  endfunction

  assign pos_run = {1'b0, pos_q} + {1'b0, run_q};

  // status toward the controller
  assign stat_o.cmd        = cmd_q;
  assign stat_o.pos_gt_len = pos_q > len_q;
  assign stat_o.pos_ge_len = pos_q >= len_q;
  assign stat_o.full       = len_q == LEN_W'(CAP);
  assign stat_o.run_bad    = (run_q == '0) || (pos_run > {1'b0, len_q});
  assign stat_o.i_lt_len   = i_q < len_q;
  assign stat_o.k_gt_pos   = k_q > pos_q;
  assign stat_o.i_lt_j     = i_q < j_q;
  assign stat_o.hit        = rda_q == val_q;
  assign stat_o.less       = val_q < rda_q;

  // write address and data select
  always_comb begin
    unique case (ctrl_i.wa_sel)
      WA_I:    wa = i_q[IDX_W-1:0];
      WA_J:    wa = j_q[IDX_W-1:0];
      WA_K:    wa = k_q[IDX_W-1:0];
      WA_POS:  wa = pos_q[IDX_W-1:0];
      default: wa = pos_q[IDX_W-1:0];
    endcase
    unique case (ctrl_i.wd_sel)
      WD_VAL:  wd = val_q;
      WD_RDA:  wd = rda_q;
      WD_RDB:  wd = rdb_q;
      default: wd = val_q;
    endcase
  end

  // element memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wa] <= wd;
    end
    if (ctrl_i.rd_en) begin
      rda_q <= mem[i_q[IDX_W-1:0]];
      rdb_q <= mem[j_q[IDX_W-1:0]];
    end
  end

  // length update
  always_comb begin
    unique case (ctrl_i.len_op)
      LN_KEEP:    len_d = len_q;
      LN_INC:     len_d = len_q + LEN_W'(1);
      LN_SUB_RUN: len_d = len_q - run_q;
      LN_FROM_K:  len_d = k_q;
      default:    len_d = len_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // command word, indexes and result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      cmd_q      <= cmd_e'(command_i);
      pos_q      <= LEN_W'(position_i);
      run_q      <= LEN_W'(run_count_i);
      val_q      <= value_i;
      res_st_q   <= ST_OK;
      res_rd_q   <= '0;
      res_fidx_q <= '0;
    end else begin
      if (ctrl_i.run_one) begin
        run_q <= LEN_W'(1);
      end
      unique case (ctrl_i.pos_op)
        PS_LEN:  pos_q <= len_q;
        PS_I:    pos_q <= i_q;
        default: pos_q <= pos_q;
      endcase
      if (ctrl_i.set_status) begin
        res_st_q <= ctrl_i.status;
      end
      if (ctrl_i.cap_rd) begin
        res_rd_q <= rda_q;
      end
      if (ctrl_i.cap_fidx) begin
        res_fidx_q <= i_q[IDX_W-1:0];
      end
    end
    i_q <= idx_next(ctrl_i.i_op, i_q, len_q, pos_q, run_q);
    j_q <= idx_next(ctrl_i.j_op, j_q, len_q, pos_q, run_q);
    k_q <= idx_next(ctrl_i.k_op, k_q, len_q, pos_q, run_q);
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      status_o      <= res_st_q;
      read_value_o  <= res_rd_q;
      found_index_o <= res_fidx_q;
      list_length_o <= len_q;
    end
  end

`ifndef ASSERT_OFF
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAP))
    else $error("list length above capacity");
  a_grow_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.len_op == LN_INC |-> len_q < LEN_W'(CAP))
    else $error("length grows on a full list");
`endif

endmodule

// ===== design/bale_ctrl.sv =====
// Controller FSM of the list engine: sequences memory reads, writes and index steps.
// Depends on bale_pkg; drives bale_dpath.
module bale_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  bale_pkg::dp_stat_t stat_i,
  output bale_pkg::dp_ctrl_t ctrl_o
);
  import bale_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        unique case (stat_i.cmd)
          CMD_APPEND: begin
            if (stat_i.full) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_FULL;
            end else begin
              ctrl_o.pos_op = PS_LEN;
              ctrl_o.k_op   = IX_LEN;
              ctrl_o.i_op   = IX_LEN_M1;
              state_d       = S_INS_RD;
            end
          end
          CMD_INSERT: begin
            if (stat_i.pos_gt_len) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_RANGE;
            end else if (stat_i.full) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_FULL;
            end else begin
              ctrl_o.k_op = IX_LEN;
              ctrl_o.i_op = IX_LEN_M1;
              state_d     = S_INS_RD;
            end
          end
          CMD_DELETE: begin
            if (stat_i.pos_ge_len) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_RANGE;
            end else begin
              ctrl_o.run_one = 1'b1;
              ctrl_o.k_op    = IX_POS;
              state_d        = S_DEL_SET;
            end
          end
          CMD_DEL_RUN: begin
            if (stat_i.run_bad) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_RANGE;
            end else begin
              ctrl_o.i_op = IX_POS_RUN;
              ctrl_o.k_op = IX_POS;
              state_d     = S_DEL_RD;
            end
          end
          CMD_READ: begin
            if (stat_i.pos_ge_len) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_RANGE;
            end else begin
              ctrl_o.i_op = IX_POS;
              state_d     = S_RD_ISSUE;
            end
          end
          CMD_WRITE: begin
            if (stat_i.pos_ge_len) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_RANGE;
            end else begin
              ctrl_o.wr_en  = 1'b1;
              ctrl_o.wa_sel = WA_POS;
              ctrl_o.wd_sel = WD_VAL;
            end
          end
          CMD_FIND: begin
            ctrl_o.set_status = 1'b1;
            ctrl_o.status     = ST_NOTFOUND;
            ctrl_o.i_op       = IX_ZERO;
            state_d           = S_FIND_RD;
          end
          CMD_SORT_INS: begin
            if (stat_i.full) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_FULL;
            end else begin
              ctrl_o.i_op = IX_ZERO;
              state_d     = S_SORT_RD;
            end
          end
          CMD_REMOVE: begin
            ctrl_o.i_op = IX_ZERO;
            ctrl_o.k_op = IX_ZERO;
            state_d     = S_REM_RD;
          end
          CMD_REVERSE: begin
            ctrl_o.i_op = IX_ZERO;
            ctrl_o.j_op = IX_LEN_M1;
            state_d     = S_REV_RD;
          end
          default: begin
            ctrl_o.set_status = 1'b1;
            ctrl_o.status     = ST_RANGE;
          end
        endcase
      end
      // shift the tail up by one, then drop the new element in place
      S_INS_RD: begin
        if (stat_i.k_gt_pos) begin
          ctrl_o.rd_en = 1'b1;
          state_d      = S_INS_WR;
        end else begin
          ctrl_o.wr_en  = 1'b1;
          ctrl_o.wa_sel = WA_POS;
          ctrl_o.wd_sel = WD_VAL;
          ctrl_o.len_op = LN_INC;
          state_d       = S_DONE;
        end
      end
      S_INS_WR: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wa_sel = WA_K;
        ctrl_o.wd_sel = WD_RDA;
        ctrl_o.k_op   = IX_DEC;
        ctrl_o.i_op   = IX_DEC;
        state_d       = S_INS_RD;
      end
      // single delete: run length is one now, start reading past the gap
      S_DEL_SET: begin
        ctrl_o.i_op = IX_POS_RUN;
        state_d     = S_DEL_RD;
      end
      // shift the tail down by the run length
      S_DEL_RD: begin
        if (stat_i.i_lt_len) begin
          ctrl_o.rd_en = 1'b1;
          state_d      = S_DEL_WR;
        end else begin
          ctrl_o.len_op = LN_SUB_RUN;
          state_d       = S_DONE;
        end
      end
      S_DEL_WR: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wa_sel = WA_K;
        ctrl_o.wd_sel = WD_RDA;
        ctrl_o.k_op   = IX_INC;
        ctrl_o.i_op   = IX_INC;
        state_d       = S_DEL_RD;
      end
      S_RD_ISSUE: begin
        ctrl_o.rd_en = 1'b1;
        state_d      = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        ctrl_o.cap_rd = 1'b1;
        state_d       = S_DONE;
      end
      // linear search for the first equal entry
      S_FIND_RD: begin
        if (stat_i.i_lt_len) begin
          ctrl_o.rd_en = 1'b1;
          state_d      = S_FIND_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FIND_CHK: begin
        if (stat_i.hit) begin
          ctrl_o.set_status = 1'b1;
          ctrl_o.status     = ST_OK;
          ctrl_o.cap_fidx   = 1'b1;
          state_d           = S_DONE;
        end else begin
          ctrl_o.i_op = IX_INC;
          state_d     = S_FIND_RD;
        end
      end
      // find the first greater entry, then insert there
      S_SORT_RD: begin
        if (stat_i.i_lt_len) begin
          ctrl_o.rd_en = 1'b1;
          state_d      = S_SORT_CHK;
        end else begin
          ctrl_o.pos_op = PS_I;
          ctrl_o.k_op   = IX_LEN;
          ctrl_o.i_op   = IX_LEN_M1;
          state_d       = S_INS_RD;
        end
      end
      S_SORT_CHK: begin
        if (stat_i.less) begin
          ctrl_o.pos_op = PS_I;
          ctrl_o.k_op   = IX_LEN;
          ctrl_o.i_op   = IX_LEN_M1;
          state_d       = S_INS_RD;
        end else begin
          ctrl_o.i_op = IX_INC;
          state_d     = S_SORT_RD;
        end
      end
      // compact in order, dropping equal entries
      S_REM_RD: begin
        if (stat_i.i_lt_len) begin
          ctrl_o.rd_en = 1'b1;
          state_d      = S_REM_CHK;
        end else begin
          ctrl_o.len_op = LN_FROM_K;
          state_d       = S_DONE;
        end
      end
      S_REM_CHK: begin
        if (!stat_i.hit) begin
          ctrl_o.wr_en  = 1'b1;
          ctrl_o.wa_sel = WA_K;
          ctrl_o.wd_sel = WD_RDA;
          ctrl_o.k_op   = IX_INC;
        end
        ctrl_o.i_op = IX_INC;
        state_d     = S_REM_RD;
      end
      // swap from both ends inward
      S_REV_RD: begin
        if (stat_i.i_lt_j) begin
          ctrl_o.rd_en = 1'b1;
          state_d      = S_REV_WA;
        end else begin
          state_d = S_DONE;
        end
      end
      S_REV_WA: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wa_sel = WA_I;
        ctrl_o.wd_sel = WD_RDB;
        state_d       = S_REV_WB;
      end
      S_REV_WB: begin
        ctrl_o.wr_en  = 1'b1;
        ctrl_o.wa_sel = WA_J;
        ctrl_o.wd_sel = WD_RDA;
        ctrl_o.i_op   = IX_INC;
        ctrl_o.j_op   = IX_DEC;
        state_d       = S_REV_RD;
      end
      // hand the result word over once the output register is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o)
    else $error("input taken while busy");
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |=> out_valid_o)
    else $error("result word loaded but not valid");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("pending result word overwritten");
  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.wr_en |-> !ctrl_o.rd_en)
    else $error("read and write issued together");
`endif

endmodule
